/* sv/m_of_n_detection_persistence_top_defines.svh */
// Assertion macros for the m-of-n detection persistence block.
// Used by the queue and the back end; needs clk_i and rst_ni in scope.
`ifndef M_OF_N_DETECTION_PERSISTENCE_TOP_DEFINES_SVH
`define M_OF_N_DETECTION_PERSISTENCE_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is applied.
`define MNDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its trigger.
`define MNDP_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mndp_pkg.sv */
// Shared types and constants of the m-of-n detection persistence block.
// No dependencies.
package mndp_pkg;

  localparam int unsigned PosW   = 20;
  localparam int unsigned RangeW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 3'd0,
    CFG_HITS_NEEDED = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_NEAR = 3'd3,
    CFG_MID = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_NEAR = 2'd0,
    CLS_MID = 2'd1,
    CLS_FAR = 2'd2
  } range_class_e;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [RangeW-1:0] sensor_range;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic confirmed;
    logic signed [PosW-1:0] out_x;
    logic signed [PosW-1:0] out_y;
    logic [1:0] range_class;
    logic [3:0] hit_count;
    logic [5:0] confirm_index;
    logic last_of_frame;
  } out_item_t;

  // Classified item as it waits between front and back end.
  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [1:0] range_class;
    logic frame_end;
  } queued_t;

  typedef struct packed {
    logic [3:0] window_frames;
    logic [3:0] hits_needed;
    logic [15:0] match_radius;
    logic [15:0] near_limit;
    logic [15:0] mid_limit;
  } cfg_t;

endpackage

/* sv/mndp_front.sv */
// Front end: accepts detections and classifies them by sensor range.
// Depends on mndp_pkg; feeds mndp_queue.
module mndp_front import mndp_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output queued_t  q_data_o
);

  logic [1:0] cls;

  // Near is tested first, so limits out of order still give a defined class.
  always_comb begin
    if (in_data_i.sensor_range < cfg_i.near_limit) begin
      cls = CLS_NEAR;
    end else if (in_data_i.sensor_range < cfg_i.mid_limit) begin
      cls = CLS_MID;
    end else begin
      cls = CLS_FAR;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o = in_valid_i && !q_full_i;
  assign q_data_o = '{pos_x: in_data_i.pos_x, pos_y: in_data_i.pos_y,
                      range_class: cls, frame_end: in_data_i.frame_end};

endmodule

/* sv/mndp_queue.sv */
// Two-entry queue between the front and back ends.
// Depends on mndp_pkg and the assertion macro header.
`include "m_of_n_detection_persistence_top_defines.svh"
module mndp_queue import mndp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  queued_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output queued_t pop_data_o,
  output logic    empty_o
);

  queued_t     mem_q [2];
  logic        wr_q;
  logic        rd_q;
  logic [1:0]  cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  `MNDP_ASSERT(a_cnt_bound, cnt_q <= 2'd2, "queue count out of range")
  `MNDP_ASSERT(a_no_overflow, !(push_i && full_o), "push into full queue")
  `MNDP_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from empty queue")

endmodule

/* sv/mndp_back.sv */
// Back end: scans the frame history one stored detection at a time,
// stores the item and drives the result register. Depends on mndp_pkg.
`include "m_of_n_detection_persistence_top_defines.svh"
module mndp_back import mndp_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned MAX_DETS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  queued_t   q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned SW = $clog2(MAX_FRAMES);
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW = $clog2(MAX_DETS + 1);
  localparam int unsigned Depth = MAX_FRAMES * MAX_DETS;
  localparam int unsigned AW = $clog2(Depth);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FRAME = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DIFF  = 7'b0001000,
    S_SQ    = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q;
  queued_t item_q;
  logic [FW-1:0] k_q;
  logic [FW-1:0] win_q;
  logic [FW-1:0] hits_q;
  logic [CW-1:0] i_q;
  logic [CW-1:0] n_q;
  logic [SW-1:0] slot_q;
  logic [31:0] r2_q;

  logic [SW-1:0] head_q;
  logic [SW-1:0] held_q;
  logic [CW-1:0] cur_q;
  logic [5:0] seq_q;
  logic [CW-1:0] slot_cnt_q [MAX_FRAMES];

  logic [2*PosW-1:0] mem_q [Depth];
  logic [2*PosW-1:0] rd_q;
  logic [PosW:0] adx_q, ady_q;
  logic [2*PosW+1:0] sqx_q, sqy_q;

  logic out_valid_q;
  out_item_t out_q;

  logic [FW-1:0] win_d;
  logic [SW-1:0] slot_d;
  logic [SW-1:0] head_d;
  logic signed [PosW:0] dx, dy;
  logic [2*PosW+2:0] dist_sum;
  logic store;
  logic out_free;
  logic fire;
  logic conf;

  always_comb begin
    if (cfg_i.window_frames == 4'd0) begin
      win_d = FW'(1);
    end else if (int'(cfg_i.window_frames) > MAX_FRAMES) begin
      win_d = FW'(MAX_FRAMES);
    end else begin
      win_d = FW'(cfg_i.window_frames);
    end
  end

  // Ring slot k frames back from the current one.
  always_comb begin
    if (int'(head_q) >= int'(k_q)) begin
      slot_d = SW'(int'(head_q) - int'(k_q));
    end else begin
      slot_d = SW'(int'(head_q) + MAX_FRAMES - int'(k_q));
    end
  end

  assign head_d = (int'(head_q) == MAX_FRAMES - 1) ? '0 : head_q + SW'(1);
  assign dx = {item_q.pos_x[PosW-1], item_q.pos_x} -
              {rd_q[2*PosW-1], rd_q[2*PosW-1:PosW]};
  assign dy = {item_q.pos_y[PosW-1], item_q.pos_y} -
              {rd_q[PosW-1], rd_q[PosW-1:0]};
  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire = (state_q == S_FIN) && out_free;
  assign store = (state_q == S_FIN) && out_free && (int'(cur_q) < MAX_DETS);
  assign conf = int'(hits_q) >= int'(cfg_i.hits_needed);
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // History memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[AW'(int'(head_q) * MAX_DETS + int'(cur_q))] <= {item_q.pos_x, item_q.pos_y};
    end
    rd_q <= mem_q[AW'(int'(slot_q) * MAX_DETS + int'(i_q))];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_data_i;
    adx_q <= dx[PosW] ? (PosW+1)'(-dx) : (PosW+1)'(dx);
    ady_q <= dy[PosW] ? (PosW+1)'(-dy) : (PosW+1)'(dy);
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
    if (state_q == S_FIN && out_free) begin
      out_q.confirmed <= conf;
      out_q.out_x <= item_q.pos_x;
      out_q.out_y <= item_q.pos_y;
      out_q.range_class <= item_q.range_class;
      out_q.hit_count <= 4'(hits_q);
      out_q.confirm_index <= conf ? seq_q : 6'd0;
      out_q.last_of_frame <= item_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= '0;
      win_q <= '0;
      hits_q <= '0;
      i_q <= '0;
      n_q <= '0;
      slot_q <= '0;
      r2_q <= '0;
      head_q <= '0;
      held_q <= '0;
      cur_q <= '0;
      seq_q <= '0;
      out_valid_q <= 1'b0;
      for (int f = 0; f < MAX_FRAMES; f++) slot_cnt_q[f] <= '0;
    end else begin
      out_valid_q <= fire || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            k_q <= FW'(1);
            hits_q <= FW'(1);
            win_q <= win_d;
            r2_q <= cfg_i.match_radius * cfg_i.match_radius;
            state_q <= S_FRAME;
          end
        end
        S_FRAME: begin
          if (k_q < win_q && int'(k_q) <= int'(held_q)) begin
            slot_q <= slot_d;
            n_q <= slot_cnt_q[slot_d];
            i_q <= '0;
            if (slot_cnt_q[slot_d] == '0) k_q <= k_q + FW'(1);
            else state_q <= S_READ;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_READ: state_q <= S_DIFF;
        S_DIFF: state_q <= S_SQ;
        S_SQ: state_q <= S_CMP;
        S_CMP: begin
          // A previous frame counts once: the first match ends its scan.
          if (dist_sum < {11'd0, r2_q}) begin
            hits_q <= hits_q + FW'(1);
            k_q <= k_q + FW'(1);
            state_q <= S_FRAME;
          end else if (i_q + CW'(1) < n_q) begin
            i_q <= i_q + CW'(1);
            state_q <= S_READ;
          end else begin
            k_q <= k_q + FW'(1);
            state_q <= S_FRAME;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (store) slot_cnt_q[head_q] <= cur_q + CW'(1);
            if (item_q.frame_end) begin
              head_q <= head_d;
              slot_cnt_q[head_d] <= '0;
              if (int'(held_q) < MAX_FRAMES - 1) held_q <= held_q + SW'(1);
              cur_q <= '0;
              seq_q <= '0;
            end else begin
              if (conf) seq_q <= seq_q + 6'd1;
              if (store) cur_q <= cur_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MNDP_ASSERT(a_hits_bound, (state_q != S_FIN) || (hits_q <= win_q), "hits exceed window")
  `MNDP_ASSERT(a_cur_bound, int'(cur_q) <= MAX_DETS, "frame fill beyond capacity")
  `MNDP_ASSERT_NEXT(a_sq_cmp, state_q == S_SQ, state_q == S_CMP, "compare step skipped")
  `MNDP_ASSERT_NEXT(a_pop_start, q_pop_o, state_q == S_FRAME, "popped item not scanned")

endmodule

/* sv/m_of_n_detection_persistence_top.sv */
// Top level of the m-of-n detection persistence block: configuration
// registers, front end, queue and back end. Depends on mndp_pkg.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i (in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// The back end visits each previous frame in the window and compares the
// item with its stored detections up to the first match; each compare walks
// the history memory read, difference, square and compare steps in turn.
// Reset clears all control state; the history memory needs no clearing.
// The front end keeps accepting into a two-entry queue, until it is full,
// while the back end scans or waits on a stalled output.
module m_of_n_detection_persistence_top import mndp_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned MAX_DETS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty;
  queued_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_frames <= 4'd5;
      cfg_q.hits_needed <= 4'd3;
      cfg_q.match_radius <= 16'd256;
      cfg_q.near_limit <= 16'd1280;
      cfg_q.mid_limit <= 16'd2560;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW: cfg_q.window_frames <= cfg_wdata_i[3:0];
        CFG_HITS_NEEDED: cfg_q.hits_needed <= cfg_wdata_i[3:0];
        CFG_RADIUS: cfg_q.match_radius <= cfg_wdata_i;
        CFG_NEAR: cfg_q.near_limit <= cfg_wdata_i;
        CFG_MID: cfg_q.mid_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mndp_front u_front (
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .cfg_i(cfg_q), .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  mndp_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(q_push), .push_data_i(q_in),
    .full_o(q_full), .pop_i(q_pop), .pop_data_o(q_out), .empty_o(q_empty)
  );

  mndp_back #(.MAX_FRAMES(MAX_FRAMES), .MAX_DETS(MAX_DETS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .q_empty_i(q_empty),
    .q_data_i(q_out), .q_pop_o(q_pop), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

endmodule
